>>> sv/scsr_pkg.sv
// Shared types, constants and the scan code table for the setpoint ramper.
`default_nettype none
package scsr_pkg;

   localparam int NUM_KEYS         = 10;
   localparam int NUM_OUT          = 5;
   localparam int CHANNELS_DEFAULT = 5;
   localparam int DATA_W           = 8;
   localparam int COUNT_W          = DATA_W + 1;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W      = 3;

   localparam logic [DATA_W-1:0] BREAK_CODE     = 8'hF0;
   localparam logic [DATA_W-1:0] SETPOINT_RESET = 8'd90;

   localparam logic [DATA_W-1:0] KEY_CODES [NUM_KEYS] = '{
      8'h1C, 8'h1A, 8'h1B, 8'h22, 8'h23, 8'h21, 8'h2B, 8'h2A, 8'h34, 8'h32
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_HOLD_THRESHOLD = 3'd0,
      CFG_SLOW_UP_STEP   = 3'd1,
      CFG_FAST_UP_STEP   = 3'd2,
      CFG_SLOW_DOWN_STEP = 3'd3,
      CFG_FAST_DOWN_STEP = 3'd4,
      CFG_UPPER_LIMIT    = 3'd5
   } cfg_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] hold_threshold;
      logic [DATA_W-1:0] slow_up_step;
      logic [DATA_W-1:0] fast_up_step;
      logic [DATA_W-1:0] slow_down_step;
      logic [DATA_W-1:0] fast_down_step;
      logic [DATA_W-1:0] upper_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hold_threshold: 8'd20,
      slow_up_step:   8'd1,
      fast_up_step:   8'd10,
      slow_down_step: 8'd1,
      fast_down_step: 8'd10,
      upper_limit:    8'd180
   };

   typedef logic [NUM_KEYS-1:0] keys_type;

   typedef struct packed {
      logic     valid;
      keys_type keys;
   } key_push_type;

   function automatic keys_type key_match(input logic [DATA_W-1:0] code);
      keys_type hit;
      for (int k = 0; k < NUM_KEYS; k++) begin
         hit[k] = (KEY_CODES[k] == code);
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

>>> sv/scan_code_setpoint_ramper_unit.sv
// Top level: scan-code driven setpoint ramper with a decoupled front and back.
// Path: a request's key snapshot is registered in the key queue, then its setpoints are
// registered in the result register before the result handshake.
// Throughput: one transaction per cycle while the two-entry key queue has room;
// it absorbs output stalls until full. Each channel gets one add/clamp/subtract pass.
// Synchronous reset empties the queue, clears key flags and hold counters, reloads the
// config defaults and returns every setpoint to 90.
`default_nettype none
module scan_code_setpoint_ramper_unit #(
   parameter int CHANNELS = scsr_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   input  wire logic [scsr_pkg::DATA_W-1:0]                 req_tdata,  // [7:0] scan_byte
   input  wire logic                                        req_tuser,  // [0] byte_valid
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // [7:0] position_a, [15:8] position_b, [23:16] position_c,
   // [31:24] position_d, [39:32] position_e
   output logic [scsr_pkg::NUM_OUT*scsr_pkg::DATA_W-1:0]    rsp_tdata,
   input  wire logic                                        csr_we,
   input  wire logic [scsr_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [scsr_pkg::DATA_W-1:0]                 csr_wdata
);
   import scsr_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   key_push_type push;
   logic         q_ready, q_valid, q_pop;
   keys_type     q_keys;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CFG_HOLD_THRESHOLD: cfg_in.hold_threshold = csr_wdata;
            CFG_SLOW_UP_STEP:   cfg_in.slow_up_step   = csr_wdata;
            CFG_FAST_UP_STEP:   cfg_in.fast_up_step   = csr_wdata;
            CFG_SLOW_DOWN_STEP: cfg_in.slow_down_step = csr_wdata;
            CFG_FAST_DOWN_STEP: cfg_in.fast_down_step = csr_wdata;
            CFG_UPPER_LIMIT:    cfg_in.upper_limit    = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = q_ready;

   scsr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_byte_valid (req_tuser),
      .in_scan_byte  (req_tdata),
      .q_ready       (q_ready),
      .push          (push)
   );

   scsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_keys   (q_keys)
   );

   scsr_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_keys    (q_keys),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> sv/scsr_front.sv
// Front end: takes scan transactions and tracks the held-key flags.
`default_nettype none
module scsr_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic                        in_byte_valid,
   input  wire logic [scsr_pkg::DATA_W-1:0] in_scan_byte,
   input  wire logic                        q_ready,
   output scsr_pkg::key_push_type           push
);
   import scsr_pkg::*;

   keys_type key_flags_ff, key_flags_in;
   logic     release_pending_ff, release_pending_in;
   keys_type hit;
   logic     take;

   assign take = in_valid && q_ready;
   assign hit  = key_match(in_scan_byte);

   always_comb begin
      key_flags_in       = key_flags_ff;
      release_pending_in = release_pending_ff;
      if (take && in_byte_valid) begin
         if (in_scan_byte == BREAK_CODE) begin
            release_pending_in = 1'b1;
         end else begin
            if (release_pending_ff) begin
               key_flags_in = key_flags_ff & ~hit;
            end else begin
               key_flags_in = key_flags_ff | hit;
            end
            release_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_flags_ff       <= '0;
         release_pending_ff <= 1'b0;
      end else begin
         key_flags_ff       <= key_flags_in;
         release_pending_ff <= release_pending_in;
      end
   end

   assign push.valid = take;
   assign push.keys  = key_flags_in;

endmodule
`default_nettype wire

>>> sv/scsr_queue.sv
// Two-entry queue of key snapshots between front and back.
`default_nettype none
module scsr_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire scsr_pkg::key_push_type  push,
   output logic                         push_ready,
   input  wire logic                    pop,
   output logic                         pop_valid,
   output scsr_pkg::keys_type           pop_keys
);
   import scsr_pkg::*;

   keys_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_keys   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.keys;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

>>> sv/scsr_back.sv
// Back end: hold counters, setpoint ramping and the result register.
`default_nettype none
module scsr_back #(
   parameter int CHANNELS = scsr_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire scsr_pkg::cfg_type                         cfg,
   input  wire logic                                      q_valid,
   input  wire scsr_pkg::keys_type                        q_keys,
   output logic                                           q_pop,
   output logic                                           out_valid,
   input  wire logic                                      out_ready,
   output logic [scsr_pkg::NUM_OUT*scsr_pkg::DATA_W-1:0]  out_data
);
   import scsr_pkg::*;

   logic out_valid_ff, out_valid_in;

   assign q_pop = q_valid && (!out_valid_ff || out_ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

   for (genvar i = 0; i < NUM_OUT; i++) begin : g_chan
      if (i < CHANNELS) begin : g_live
         logic [DATA_W-1:0]  sp_ff, sp_in;
         logic [COUNT_W-1:0] up_cnt_ff, up_cnt_in;
         logic [COUNT_W-1:0] dn_cnt_ff, dn_cnt_in;
         logic               up_held, dn_held;
         logic [DATA_W-1:0]  up_step, dn_step, after_up;
         logic [COUNT_W-1:0] up_sum;
         logic [COUNT_W-1:0] thr;

         assign thr     = {1'b0, cfg.hold_threshold};
         assign up_held = q_keys[2*i];
         assign dn_held = q_keys[2*i+1];

         always_comb begin
            up_cnt_in = '0;
            dn_cnt_in = '0;
            if (up_held) begin
               up_cnt_in = (up_cnt_ff <= thr) ? up_cnt_ff + 1'b1 : up_cnt_ff;
            end
            if (dn_held) begin
               dn_cnt_in = (dn_cnt_ff <= thr) ? dn_cnt_ff + 1'b1 : dn_cnt_ff;
            end
            up_step = (up_cnt_in > thr) ? cfg.fast_up_step : cfg.slow_up_step;
            dn_step = (dn_cnt_in > thr) ? cfg.fast_down_step : cfg.slow_down_step;
            up_sum  = {1'b0, sp_ff} + {1'b0, up_step};
            after_up = sp_ff;
            if (up_held) begin
               after_up = (up_sum > {1'b0, cfg.upper_limit}) ? cfg.upper_limit
                                                             : up_sum[DATA_W-1:0];
            end
            sp_in = after_up;
            if (dn_held) begin
               sp_in = (after_up > dn_step) ? after_up - dn_step : '0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               sp_ff     <= SETPOINT_RESET;
               up_cnt_ff <= '0;
               dn_cnt_ff <= '0;
            end else if (q_pop) begin
               sp_ff     <= sp_in;
               up_cnt_ff <= up_cnt_in;
               dn_cnt_ff <= dn_cnt_in;
            end
         end

         assign out_data[i*DATA_W +: DATA_W] = sp_ff;
      end else begin : g_idle
         assign out_data[i*DATA_W +: DATA_W] = '0;
      end
   end

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_valid && (!out_valid_ff || out_ready)))
      else $error("pop while result slot occupied");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> (out_valid_ff && $stable(out_data)))
      else $error("stalled result changed");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> out_valid_ff)
      else $error("popped transaction not presented");

endmodule
`default_nettype wire

>>> tb/sv/setpoint_ramp_checker.sv
// Checker for the setpoint ramper: predicts each tick's setpoints and compares results.
`timescale 1ns / 100ps
module setpoint_ramp_checker (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_tvalid,
   input  wire logic                                        req_tready,
   input  wire logic [scsr_pkg::DATA_W-1:0]                 req_tdata,  // [7:0] scan_byte
   input  wire logic                                        req_tuser,  // [0] byte_valid
   input  wire logic                                        rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // [7:0] position_a, [15:8] position_b, [23:16] position_c,
   // [31:24] position_d, [39:32] position_e
   input  wire logic [scsr_pkg::NUM_OUT*scsr_pkg::DATA_W-1:0] rsp_tdata,
   input  wire logic                                        csr_we,
   input  wire logic [scsr_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [scsr_pkg::DATA_W-1:0]                 csr_wdata,
   output int                                               mismatch_count,
   output int                                               results_owed
);
   import scsr_pkg::*;

   typedef logic [NUM_OUT-1:0][DATA_W-1:0] positions_type;

   cfg_type       ramp_cfg;
   keys_type      held_keys;
   logic          break_armed;
   int unsigned   up_hold   [NUM_OUT];
   int unsigned   down_hold [NUM_OUT];
   int unsigned   setpoint  [NUM_OUT];
   positions_type owed_positions [$];

   task automatic note_mismatch(input string what, input int wanted, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, wanted, got);
      end
   endtask

   task automatic advance_ramp(input logic present, input logic [DATA_W-1:0] code,
                               output positions_type positions);
      int unsigned level;
      int unsigned step;
      if (present) begin
         if (code == BREAK_CODE) begin
            break_armed = 1'b1;
         end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (KEY_CODES[k] == code) begin
                  held_keys[k] = !break_armed;
               end
            end
            break_armed = 1'b0;
         end
      end
      for (int ch = 0; ch < NUM_OUT; ch++) begin
         level = setpoint[ch];
         if (held_keys[2*ch]) begin
            if (up_hold[ch] <= ramp_cfg.hold_threshold) up_hold[ch]++;
            step = (up_hold[ch] > ramp_cfg.hold_threshold) ? ramp_cfg.fast_up_step
                                                            : ramp_cfg.slow_up_step;
            level += step;
            if (level > ramp_cfg.upper_limit) level = ramp_cfg.upper_limit;
         end else begin
            up_hold[ch] = 0;
         end
         if (held_keys[2*ch+1]) begin
            if (down_hold[ch] <= ramp_cfg.hold_threshold) down_hold[ch]++;
            step = (down_hold[ch] > ramp_cfg.hold_threshold) ? ramp_cfg.fast_down_step
                                                              : ramp_cfg.slow_down_step;
            level = (level > step) ? level - step : 0;
         end else begin
            down_hold[ch] = 0;
         end
         setpoint[ch]  = level & 8'hFF;
         positions[ch] = DATA_W'(setpoint[ch]);
      end
   endtask

   always @(posedge clock) begin : monitor
      positions_type wanted;
      positions_type fresh;
      if (reset) begin
         ramp_cfg    = CFG_RESET;
         held_keys   = '0;
         break_armed = 1'b0;
         for (int ch = 0; ch < NUM_OUT; ch++) begin
            up_hold[ch]   = 0;
            down_hold[ch] = 0;
            setpoint[ch]  = SETPOINT_RESET;
         end
         owed_positions.delete();
         mismatch_count = 0;
         results_owed   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_positions.size() == 0) begin
               note_mismatch("unexpected result transaction", 0, 1);
            end else begin
               wanted = owed_positions.pop_front();
               for (int ch = 0; ch < NUM_OUT; ch++) begin
                  if (rsp_tdata[ch*DATA_W +: DATA_W] !== wanted[ch]) begin
                     note_mismatch($sformatf("position of channel %0d", ch),
                                   int'(wanted[ch]), int'(rsp_tdata[ch*DATA_W +: DATA_W]));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            advance_ramp(req_tuser, req_tdata, fresh);
            owed_positions.push_back(fresh);
         end
         if (csr_we) begin
            case (csr_index)
               CFG_HOLD_THRESHOLD: ramp_cfg.hold_threshold = csr_wdata;
               CFG_SLOW_UP_STEP:   ramp_cfg.slow_up_step   = csr_wdata;
               CFG_FAST_UP_STEP:   ramp_cfg.fast_up_step   = csr_wdata;
               CFG_SLOW_DOWN_STEP: ramp_cfg.slow_down_step = csr_wdata;
               CFG_FAST_DOWN_STEP: ramp_cfg.fast_down_step = csr_wdata;
               CFG_UPPER_LIMIT:    ramp_cfg.upper_limit    = csr_wdata;
               default: ;
            endcase
         end
         results_owed = owed_positions.size();
      end
   end

endmodule

>>> tb/sv/scan_code_setpoint_ramper_unit_tb.sv
// Testbench top for the setpoint ramper: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module scan_code_setpoint_ramper_unit_tb;
   import scsr_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 165;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam logic [DATA_W-1:0]      UNKNOWN_CODE   = 8'h77;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic [DATA_W-1:0]           req_tdata  = '0;
   logic                        req_tuser  = 1'b0;
   logic                        rsp_tready = 1'b0;
   logic                        csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index  = '0;
   logic [DATA_W-1:0]           csr_wdata  = '0;
   wire logic                   req_tready;
   wire logic                   rsp_tvalid;
   wire logic [NUM_OUT*DATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int results_owed;
   int cycle_count    = 0;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_request   = 1'b0;

   always #5 clock = ~clock;

   scan_code_setpoint_ramper_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   setpoint_ramp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // result side flow control
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("scan_code_setpoint_ramper_unit_tb failed");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_tick(input logic present, input logic [DATA_W-1:0] code);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= present;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] su,
                            input logic [DATA_W-1:0] fu, input logic [DATA_W-1:0] sd,
                            input logic [DATA_W-1:0] fd, input logic [DATA_W-1:0] ul);
      write_reg(CFG_HOLD_THRESHOLD, thr);
      write_reg(CFG_SLOW_UP_STEP, su);
      write_reg(CFG_FAST_UP_STEP, fu);
      write_reg(CFG_SLOW_DOWN_STEP, sd);
      write_reg(CFG_FAST_DOWN_STEP, fd);
      write_reg(CFG_UPPER_LIMIT, ul);
   endtask

   task automatic random_ticks(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_tick(1'b0, DATA_W'($urandom_range(0, 255)));
         end else if (pick < 65) begin
            send_tick(1'b1, KEY_CODES[$urandom_range(0, NUM_KEYS-1)]);
         end else if (pick < 85) begin
            send_tick(1'b1, BREAK_CODE);
            send_tick(1'b1, KEY_CODES[$urandom_range(0, NUM_KEYS-1)]);
            sent++;
         end else if (pick < 95) begin
            send_tick(1'b1, DATA_W'($urandom_range(0, 255)));
         end else begin
            send_tick(1'b1, BREAK_CODE);
         end
         sent++;
      end
   endtask

   initial begin : stimulus
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: valid gating, every key made, keys 0 and 9 broken, break prefix cases
      send_tick(1'b0, 8'hFF);
      send_tick(1'b0, BREAK_CODE);
      send_tick(1'b1, KEY_CODES[0]);
      send_tick(1'b1, KEY_CODES[9]);
      send_tick(1'b1, KEY_CODES[7]);
      send_tick(1'b1, 8'h00);
      send_tick(1'b1, BREAK_CODE);
      send_tick(1'b1, BREAK_CODE);
      send_tick(1'b1, KEY_CODES[0]);
      send_tick(1'b1, BREAK_CODE);
      send_tick(1'b1, UNKNOWN_CODE);
      for (int k = 1; k < NUM_KEYS - 1; k++) begin
         send_tick(1'b1, KEY_CODES[k]);
      end
      send_tick(1'b1, 8'hFF);
      send_tick(1'b0, 8'h00);
      send_tick(1'b1, BREAK_CODE);
      send_tick(1'b1, KEY_CODES[9]);
      send_tick(1'b0, 8'h00);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
               write_reg(CSR_SPARE_LOW, DATA_W'($urandom_range(0, 255)));
               write_reg(CSR_SPARE_HIGH, DATA_W'($urandom_range(0, 255)));
            end
            2: write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            3: write_all(8'd0, 8'd1, 8'd255, 8'd1, 8'd255, 8'd255);
            4: write_all(8'd3, 8'd2, 8'd7, 8'd3, 8'd9, 8'd200);
            5: write_all(8'd2, 8'd5, 8'd30, 8'd4, 8'd25, 8'd20);
            default: write_all(DATA_W'($urandom_range(0, 12)), DATA_W'($urandom_range(0, 40)),
                               DATA_W'($urandom_range(0, 40)), DATA_W'($urandom_range(0, 40)),
                               DATA_W'($urandom_range(0, 40)), DATA_W'($urandom_range(0, 255)));
         endcase
         sender_idles   = (phase != 3) && (phase != PHASES - 1);
         receiver_idles = (phase != 3) && (phase != PHASES - 1);
         if (phase == 2) hold_request = 1'b1;
         random_ticks(ITEMS_PER_PHASE);
         drain_results();
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("scan_code_setpoint_ramper_unit_tb passed");
      end else begin
         $display("scan_code_setpoint_ramper_unit_tb failed");
      end
      $finish;
   end

endmodule
